### design/mi4_pkg.sv
// shared types, widths and index helpers for the 4x4 matrix inverse
package mi4_pkg;

    localparam int ELEM_W        = 32;
    localparam int NUM_ELEM      = 16;
    localparam int COF_W         = 100;  // exact 3x3 cofactor, signed
    localparam int DET_W         = 136;  // exact 4x4 determinant, signed
    localparam int MUL_W         = 33;   // signed multiplier operand width
    localparam int FRAC_BITS_DEF = 16;

    typedef logic [NUM_ELEM-1:0][ELEM_W-1:0] t_mat;

    typedef struct packed {
        logic valid;
        t_mat mat;
    } t_push;

    // index of the i-th row (or column) left after removing x
    function automatic logic [1:0] skip_idx(input logic [1:0] x, input logic [1:0] i);
        logic [1:0] r;
        begin
            r = (i < x) ? i : i + 2'd1;
            return r;
        end
    endfunction

    // column position taken from row i in term t of a 3x3 expansion
    function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] i);
        logic [5:0] p;
        begin
            unique case (t)
                3'd0:    p = {2'd2, 2'd1, 2'd0};
                3'd1:    p = {2'd1, 2'd2, 2'd0};
                3'd2:    p = {2'd2, 2'd0, 2'd1};
                3'd3:    p = {2'd0, 2'd2, 2'd1};
                3'd4:    p = {2'd1, 2'd0, 2'd2};
                3'd5:    p = {2'd0, 2'd1, 2'd2};
                default: p = '0;
            endcase
            return p[2*i +: 2];
        end
    endfunction

    // odd permutations carry a minus sign
    function automatic logic perm_neg(input logic [2:0] t);
        return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
    endfunction

endpackage

### design/matrix_inverse_4x4.sv
// top level of the 4x4 fixed-point matrix inverse
// usage:
//   entries go in on start/i_element_in, one beat per cycle while busy is low,
//   row by row, sixteen beats per matrix in signed fixed point.
//   results come out on o_valid with o_element_out, o_singular and o_last_out,
//   sixteen beats per matrix in the same order, o_last_out on the sixteenth.
//   a loader takes the next matrix while the solver works on the current one;
//   busy rises after the sixteenth beat until the matrix moves to the queue.
// schedule:
//   the solver runs cofactors on one shared 33x33 multiplier, then the
//   determinant, then one 32-step restoring divider per entry; a singular
//   matrix is returned once its determinant is known.
// reset clears the load count, the queue and the sequencer; the receiver
// cannot stall, each result is on the ports for exactly one cycle.
module matrix_inverse_4x4
    import mi4_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic signed [ELEM_W-1:0] i_element_in,
    output logic                     busy,
    output logic                     o_valid,
    output logic signed [ELEM_W-1:0] o_element_out,
    output logic                     o_singular,
    output logic                     o_last_out
);

    t_push push;
    logic  push_ready;
    logic  q_valid;
    t_mat  q_mat;
    logic  pop;
    logic [ELEM_W-1:0] elem_out;

    mi4_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_element_in (i_element_in),
        .busy         (busy),
        .o_push       (push),
        .i_push_ready (push_ready)
    );

    mi4_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .o_valid      (q_valid),
        .o_mat        (q_mat),
        .i_pop        (pop)
    );

    mi4_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_mat         (q_mat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_element_out (elem_out),
        .o_singular    (o_singular),
        .o_last_out    (o_last_out)
    );

    assign o_element_out = elem_out;

endmodule

### design/mi4_front.sv
// front end: collects sixteen entries and hands a full matrix to the queue
module mi4_front
    import mi4_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [ELEM_W-1:0] i_element_in,
    output logic              busy,
    output t_push             o_push,
    input  logic              i_push_ready
);

    t_mat       r_store;
    logic [3:0] r_cnt;
    logic       r_full;

    logic take;
    assign take = start && !r_full;
    assign busy = r_full;

    assign o_push.valid = r_full;
    assign o_push.mat   = r_store;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_full <= 1'b0;
        end else begin
            if (take) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_full <= 1'b1;
                end
            end else if (r_full && i_push_ready) begin
                r_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_store[r_cnt] <= i_element_in;
        end
    end

endmodule

### design/mi4_queue.sv
// one-matrix hand-off slot between loader and solver
module mi4_queue
    import mi4_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_push_ready,
    output logic  o_valid,
    output t_mat  o_mat,
    input  logic  i_pop
);

    logic r_valid;
    t_mat r_mat;

    assign o_push_ready = !r_valid;
    assign o_valid      = r_valid;
    assign o_mat        = r_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end else if (i_push.valid && !r_valid) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid && !r_valid) begin
            r_mat <= i_push.mat;
        end
    end

endmodule

### design/mi4_back.sv
// solver: cofactors, determinant and per-entry division on shared units
module mi4_back
    import mi4_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_mat              i_mat,
    output logic              o_pop,
    output logic              o_valid,
    output logic [ELEM_W-1:0] o_element_out,
    output logic              o_singular,
    output logic              o_last_out
);

    localparam int NUM_W = COF_W + 2 * FRAC_BITS;
    localparam int DIV_W = ((NUM_W > DET_W) ? NUM_W : DET_W) + 2;
    localparam int DSR_W = DIV_W + 33;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_COF  = 4'd1;
    localparam logic [3:0] ST_CWB  = 4'd2;
    localparam logic [3:0] ST_DET  = 4'd3;
    localparam logic [3:0] ST_DWB  = 4'd4;
    localparam logic [3:0] ST_ABS  = 4'd5;
    localparam logic [3:0] ST_SING = 4'd6;
    localparam logic [3:0] ST_DIV0 = 4'd7;
    localparam logic [3:0] ST_DIV1 = 4'd8;
    localparam logic [3:0] ST_SAT  = 4'd9;
    localparam logic [3:0] ST_STEP = 4'd10;
    localparam logic [3:0] ST_OUT  = 4'd11;

    logic [3:0] r_st;
    logic [3:0] r_k;
    logic [2:0] r_t;
    logic [1:0] r_s;
    logic [4:0] r_n;

    logic [COF_W-1:0] r_cof [NUM_ELEM];
    logic signed [DET_W-1:0] r_acc;
    logic signed [DET_W-1:0] r_det;
    logic [DET_W-1:0]        r_ad;
    logic [ELEM_W-1:0]       r_opa;
    logic [ELEM_W-1:0]       r_ph;
    logic signed [PROD_W-1:0] r_mp;
    logic       r_tag_en;
    logic       r_tag_neg;
    logic [1:0] r_tag_sh;

    logic [DIV_W-1:0]  r_rem;
    logic [DSR_W-1:0]  r_dsr;
    logic [ELEM_W-1:0] r_q;
    logic              r_neg;
    logic              r_sat;

    logic              r_ov;
    logic [ELEM_W-1:0] r_oe;
    logic              r_os;
    logic              r_ol;

    // matrix and cofactor read ports, one address each
    logic [3:0]        mat_addr;
    logic [ELEM_W-1:0] mat_rd;
    logic [3:0]        cof_addr;
    logic [COF_W-1:0]  cof_rd;

    logic [1:0] row_r, col_c, pos_i;
    logic       term_neg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic       tag_en, tag_neg;
    logic [1:0] tag_sh;

    logic signed [DET_W-1:0] addend_ext, addend_sh, n_acc;
    logic [127:0]            cof_ext;
    logic [ELEM_W-1:0]       cof_chunk;

    logic [COF_W-1:0]  cof_abs;
    logic              ge;
    logic [ELEM_W-1:0] limit, res_val;

    assign row_r = r_k[3:2];
    assign col_c = r_k[1:0];
    assign pos_i = (r_s == 2'd0) ? 2'd0 : ((r_s == 2'd1) ? 2'd1 : 2'd2);
    assign term_neg = perm_neg(r_t) ^ row_r[0] ^ col_c[0];

    always_comb begin
        unique case (r_st)
            ST_COF:  mat_addr = {skip_idx(row_r, pos_i),
                                 skip_idx(col_c, perm_col(r_t, pos_i))};
            ST_DET:  mat_addr = {2'b00, r_k[1:0]};
            default: mat_addr = r_k;
        endcase
    end
    assign mat_rd = i_mat[mat_addr];

    assign cof_addr = (r_st == ST_DET) ? {2'b00, r_k[1:0]} : {r_k[1:0], r_k[3:2]};
    assign cof_rd   = r_cof[cof_addr];
    assign cof_ext  = {{(128 - COF_W){cof_rd[COF_W-1]}}, cof_rd};
    assign cof_chunk = cof_ext[32 * r_s +: 32];

    // shared multiplier operand selection
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        tag_en  = 1'b0;
        tag_neg = 1'b0;
        tag_sh  = 2'd0;
        if (r_st == ST_COF) begin
            mul_b = {mat_rd[ELEM_W-1], mat_rd};
            unique case (r_s)
                2'd1: mul_a = {r_opa[ELEM_W-1], r_opa};
                2'd2: begin
                    mul_a   = {1'b0, r_mp[31:0]};
                    tag_en  = 1'b1;
                    tag_neg = term_neg;
                end
                2'd3: begin
                    mul_a   = {r_ph[ELEM_W-1], r_ph};
                    tag_en  = 1'b1;
                    tag_neg = term_neg;
                    tag_sh  = 2'd1;
                end
                default: mul_a = '0;
            endcase
        end else if (r_st == ST_DET) begin
            mul_b  = {mat_rd[ELEM_W-1], mat_rd};
            mul_a  = (r_s == 2'd3) ? {cof_chunk[ELEM_W-1], cof_chunk} : {1'b0, cof_chunk};
            tag_en = 1'b1;
            tag_sh = r_s;
        end
    end
    assign mul_p = mul_a * mul_b;

    // accumulate the registered multiplier product
    assign addend_ext = {{(DET_W - PROD_W){r_mp[PROD_W-1]}}, r_mp};
    assign addend_sh  = addend_ext <<< {r_tag_sh, 5'b0};
    always_comb begin
        if (!r_tag_en) begin
            n_acc = r_acc;
        end else if (r_tag_neg) begin
            n_acc = r_acc - addend_sh;
        end else begin
            n_acc = r_acc + addend_sh;
        end
    end

    assign cof_abs = cof_rd[COF_W-1] ? COF_W'(-cof_rd) : cof_rd;
    assign ge      = {{(DSR_W - DIV_W){1'b0}}, r_rem} >= r_dsr;
    assign limit   = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign res_val = (r_sat || (r_q > limit)) ? limit : (r_neg ? (32'd0 - r_q) : r_q);

    assign o_pop = ((r_st == ST_OUT) || (r_st == ST_SING)) && (r_k == 4'd15);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_k      <= '0;
            r_t      <= '0;
            r_s      <= '0;
            r_n      <= '0;
            r_tag_en <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_tag_en <= tag_en;
            r_ov     <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    r_k <= '0;
                    r_t <= '0;
                    r_s <= '0;
                    if (i_valid) begin
                        r_st <= ST_COF;
                    end
                end
                ST_COF: begin
                    r_s <= r_s + 2'd1;
                    if (r_s == 2'd3) begin
                        if (r_t == 3'd5) begin
                            r_t  <= '0;
                            r_st <= ST_CWB;
                        end else begin
                            r_t <= r_t + 3'd1;
                        end
                    end
                end
                ST_CWB: begin
                    r_k  <= r_k + 4'd1;
                    r_st <= (r_k == 4'd15) ? ST_DET : ST_COF;
                end
                ST_DET: begin
                    r_s <= r_s + 2'd1;
                    if (r_s == 2'd3) begin
                        r_k <= r_k + 4'd1;
                        if (r_k[1:0] == 2'd3) begin
                            r_st <= ST_DWB;
                        end
                    end
                end
                ST_DWB: begin
                    r_k  <= '0;
                    r_st <= ST_ABS;
                end
                ST_ABS: begin
                    r_st <= (r_det == '0) ? ST_SING : ST_DIV0;
                end
                ST_SING: begin
                    r_ov <= 1'b1;
                    r_k  <= r_k + 4'd1;
                    if (r_k == 4'd15) begin
                        r_st <= ST_IDLE;
                    end
                end
                ST_DIV0: r_st <= ST_DIV1;
                ST_DIV1: r_st <= ST_SAT;
                ST_SAT: begin
                    r_n  <= '0;
                    r_st <= ST_STEP;
                end
                ST_STEP: begin
                    r_n <= r_n + 5'd1;
                    if (r_n == 5'd31) begin
                        r_st <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    r_ov <= 1'b1;
                    r_k  <= r_k + 4'd1;
                    r_st <= (r_k == 4'd15) ? ST_IDLE : ST_DIV0;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_mp      <= mul_p;
        r_tag_neg <= tag_neg;
        r_tag_sh  <= tag_sh;
        r_acc     <= n_acc;
        if ((r_st == ST_IDLE) || (r_st == ST_CWB) || (r_st == ST_DWB)) begin
            r_acc <= '0;
        end
        if (r_st == ST_COF && r_s == 2'd0) begin
            r_opa <= mat_rd;
        end
        if (r_st == ST_COF && r_s == 2'd2) begin
            r_ph <= r_mp[63:32];
        end
        if (r_st == ST_CWB) begin
            r_cof[r_k] <= n_acc[COF_W-1:0];
        end
        if (r_st == ST_DWB) begin
            r_det <= n_acc;
        end
        if (r_st == ST_ABS) begin
            r_ad <= r_det[DET_W-1] ? DET_W'(-r_det) : DET_W'(r_det);
        end
        if (r_st == ST_DIV0) begin
            r_rem <= {{(DIV_W - COF_W){1'b0}}, cof_abs};
            r_neg <= cof_rd[COF_W-1] ^ r_det[DET_W-1];
        end
        if (r_st == ST_DIV1) begin
            // 2|num| + |den| against 2|den|
            r_rem <= (r_rem << (2 * FRAC_BITS + 1)) + {{(DIV_W - DET_W){1'b0}}, r_ad};
            r_dsr <= {{(DSR_W - DET_W){1'b0}}, r_ad} << 33;
        end
        if (r_st == ST_SAT) begin
            r_sat <= ge;
            r_q   <= '0;
            r_dsr <= r_dsr >> 1;
        end
        if (r_st == ST_STEP) begin
            if (ge) begin
                r_rem <= r_rem - r_dsr[DIV_W-1:0];
            end
            r_q   <= {r_q[ELEM_W-2:0], ge};
            r_dsr <= r_dsr >> 1;
        end
        if (r_st == ST_OUT) begin
            r_oe <= res_val;
            r_os <= 1'b0;
            r_ol <= (r_k == 4'd15);
        end
        if (r_st == ST_SING) begin
            r_oe <= mat_rd;
            r_os <= 1'b1;
            r_ol <= (r_k == 4'd15);
        end
    end

    assign o_valid       = r_ov;
    assign o_element_out = r_oe;
    assign o_singular    = r_os;
    assign o_last_out    = r_ol;

    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_out |=> !o_valid)
        else $error("last beat not followed by a gap");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_valid)
        else $error("pop with empty queue");
    a_sing_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_SING) |-> (r_det == '0))
        else $error("singular output with nonzero determinant");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_st == ST_IDLE) && o_valid && o_last_out)
        else $error("pop not aligned with last beat");

endmodule

### sim/matrix_inverse_4x4_tb.sv
// testbench for the 4x4 fixed-point matrix inverse: random and corner matrices, scoreboard check
module matrix_inverse_4x4_tb
    import mi4_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int FRAC = FRAC_BITS_DEF;

    typedef logic signed [199:0] t_wide;

    typedef struct {
        logic [ELEM_W-1:0] element;
        logic              singular;
        logic              last;
    } t_inv_beat;

    class inverse_scoreboard;
        logic [ELEM_W-1:0] store [NUM_ELEM];
        int                load_cnt;
        t_inv_beat         pending [$];
        int                errors;

        function new();
            load_cnt = 0;
            errors   = 0;
        endfunction

        function t_wide entry(int r, int c);
            t_wide v;
            v = $signed(store[r * 4 + c]);
            return v;
        endfunction

        // signed 3x3 cofactor of position (r,c)
        function t_wide cofactor(int r, int c);
            int    rs [3];
            int    cs [3];
            int    n;
            t_wide d;
            n = 0;
            for (int i = 0; i < 4; i++) if (i != r) begin rs[n] = i; n++; end
            n = 0;
            for (int i = 0; i < 4; i++) if (i != c) begin cs[n] = i; n++; end
            d = entry(rs[0], cs[0]) * (entry(rs[1], cs[1]) * entry(rs[2], cs[2])
                                     - entry(rs[1], cs[2]) * entry(rs[2], cs[1]))
              - entry(rs[0], cs[1]) * (entry(rs[1], cs[0]) * entry(rs[2], cs[2])
                                     - entry(rs[1], cs[2]) * entry(rs[2], cs[0]))
              + entry(rs[0], cs[2]) * (entry(rs[1], cs[0]) * entry(rs[2], cs[1])
                                     - entry(rs[1], cs[1]) * entry(rs[2], cs[0]));
            if ((r + c) % 2 == 1) d = -d;
            return d;
        endfunction

        // round half away from zero, then saturate to 32 bits
        function logic [ELEM_W-1:0] div_round_sat(t_wide num, t_wide den);
            logic        neg;
            logic [199:0] an, ad, q, lim;
            neg = (num < 0) != (den < 0);
            an  = (num < 0) ? -num : num;
            ad  = (den < 0) ? -den : den;
            q   = (2 * an + ad) / (2 * ad);
            lim = neg ? 200'h8000_0000 : 200'h7FFF_FFFF;
            if (q > lim) q = lim;
            return neg ? ELEM_W'(-q) : q[ELEM_W-1:0];
        endfunction

        function void note_input(logic [ELEM_W-1:0] elem);
            t_wide     cof [NUM_ELEM];
            t_wide     det;
            t_inv_beat b;
            store[load_cnt] = elem;
            load_cnt = (load_cnt + 1) % NUM_ELEM;
            if (load_cnt != 0) return;
            for (int k = 0; k < NUM_ELEM; k++) cof[k] = cofactor(k / 4, k % 4);
            det = 0;
            for (int k = 0; k < 4; k++) det += entry(0, k) * cof[k];
            for (int k = 0; k < NUM_ELEM; k++) begin
                b.singular = (det == 0);
                b.last     = (k == NUM_ELEM - 1);
                if (det == 0) b.element = store[k];
                else b.element = div_round_sat(cof[(k % 4) * 4 + k / 4] <<< (2 * FRAC), det);
                pending.push_back(b);
            end
        endfunction

        function void check_result(logic [ELEM_W-1:0] e, logic s, logic l);
            t_inv_beat b;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected: element %h", e);
                errors++;
                return;
            end
            b = pending.pop_front();
            if (e !== b.element) begin
                $error("element_out expected %h actual %h", b.element, e); errors++;
            end
            if (s !== b.singular) begin
                $error("singular expected %0b actual %0b", b.singular, s); errors++;
            end
            if (l !== b.last) begin
                $error("last_out expected %0b actual %0b", b.last, l); errors++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic signed [ELEM_W-1:0] i_element_in = '0;
    logic                     busy;
    logic                     o_valid;
    logic signed [ELEM_W-1:0] o_element_out;
    logic                     o_singular;
    logic                     o_last_out;

    inverse_scoreboard sb = new();
    int cycles = 0;

    matrix_inverse_4x4 dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_element_in(i_element_in),
        .busy(busy), .o_valid(o_valid), .o_element_out(o_element_out),
        .o_singular(o_singular), .o_last_out(o_last_out)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n) begin
            if (start && !busy) sb.note_input(i_element_in);
            if (o_valid) sb.check_result(o_element_out, o_singular, o_last_out);
        end
    end

    function int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(120, 20);
    endfunction

    // one beat; start stays high into the next beat when there is no gap
    task automatic send_elem(logic [ELEM_W-1:0] v, int gap);
        start        <= 1'b1;
        i_element_in <= v;
        do @(posedge i_clk); while (busy);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function logic [ELEM_W-1:0] rand_elem(int mode);
        int r;
        case (mode)
            0: return $urandom();
            1: return ELEM_W'($signed($urandom_range(8 << FRAC)) - (4 << FRAC));
            default: begin
                r = $urandom_range(5);
                if (r == 0) return 32'h8000_0000;
                if (r == 1) return 32'h7FFF_FFFF;
                if (r == 2) return 32'h0000_0000;
                if (r == 3) return 32'hFFFF_FFFF;
                return $urandom_range(3, 0) << FRAC;
            end
        endcase
    endfunction

    task automatic send_matrix(logic [ELEM_W-1:0] m [NUM_ELEM]);
        for (int k = 0; k < NUM_ELEM; k++) send_elem(m[k], pick_gap());
    endtask

    initial begin
        logic [ELEM_W-1:0] m [NUM_ELEM];
        int mode;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tiny diagonal of alternating sign: inverse saturates both ways
        for (int k = 0; k < NUM_ELEM; k++) m[k] = '0;
        m[0] = 32'd1; m[5] = 32'hFFFF_FFFF; m[10] = 32'd1; m[15] = 32'hFFFF_FFFF;
        send_matrix(m);
        // all-zero matrix is singular and comes back as is
        for (int k = 0; k < NUM_ELEM; k++) m[k] = '0;
        send_matrix(m);

        for (int n = 0; n < 15; n++) begin
            mode = $urandom_range(3);
            for (int k = 0; k < NUM_ELEM; k++) m[k] = rand_elem(mode % 3);
            // mode 3: full-range random entries with a small positive diagonal (1 to 4)
            if (mode == 3)
                for (int k = 0; k < 4; k++) m[k * 5] = ELEM_W'(($urandom_range(3) + 1) << FRAC);
            // repeated row forces a singular matrix
            if ($urandom_range(4) == 0)
                for (int c = 0; c < 4; c++) m[8 + c] = m[c];
            send_matrix(m);
            if (n == 5) begin
                start <= 1'b0;
                // let the monitor note the last beat before looking at the queue
                @(posedge i_clk);
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
